>>> src/pbu_pkg.sv
// Shared constants for the pixel blend unit: field widths, blend mode codes
// and configuration register indexes.
// Has no dependencies; every other file of the block uses it.
package pbu_pkg;

	// Default number of fraction bits; ONE = 2**FRAC_BITS means 1.0.
	localparam int FRAC_BITS_DEFAULT = 15;

	// Fixed field widths of the channels.
	localparam int PIX_W      = 16;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Blend mode codes. The unused code behaves as a linear blend.
	localparam logic [MODE_W-1:0] MODE_LINEAR   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD_CLIP = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ADD_SAT  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLEND_MODE = 8'd1;

endpackage

>>> src/pbu_if.sv
// Channel interfaces of the pixel blend unit: pixel input, blended output
// and configuration write. Each carries valid, ready and its payload.
// Depends on pbu_pkg for the field widths.

// Input item: current pixel value and coverage weight.
interface pbu_pix_if;
	logic                       valid;
	logic                       ready;
	logic [pbu_pkg::PIX_W-1:0]  pixel_in;
	logic [pbu_pkg::PIX_W-1:0]  weight;

	modport source (output valid, pixel_in, weight, input ready);
	modport sink   (input valid, pixel_in, weight, output ready);
endinterface

// Result item: blended pixel value.
interface pbu_res_if;
	logic                       valid;
	logic                       ready;
	logic [pbu_pkg::PIX_W-1:0]  pixel_out;

	modport source (output valid, pixel_out, input ready);
	modport sink   (input valid, pixel_out, output ready);
endinterface

// Configuration write: register index and data.
interface pbu_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pbu_pkg::CFG_IDX_W-1:0]   index;
	logic [pbu_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> src/pixel_blend_unit.sv
// Pixel blend unit top level: configuration registers, front end stages and
// the divider pipeline. Depends on pbu_pkg, pbu_if, pbu_front, pbu_div_step.
//
// Usage: each item on the sample channel carries the current pixel value and
// a coverage weight, both unsigned fixed point where 2**FRAC_BITS means 1.0.
// Each item gives exactly one item on the blended channel, in order.
// The cfg channel writes draw_color (index 0) and blend_mode (index 1);
// other indexes are ignored. It is always ready and should be written only
// while no items are in flight.
// Modes: 0 linear blend, 1 add and clip, 2 add and saturate (divided by
// one plus the added amount); mode 3 acts as linear.
// The path is three front end stages, then one divider stage per quotient
// bit. Every mode takes the same path. Throughput is one item per cycle
// while the receiver is ready; each stage holds one item.
// Reset clears all valid bits, sets draw_color to 1.0 and the mode to linear.
// When the receiver stalls, the result holds in the last stage and earlier
// stages keep accepting items until each holds one; nothing is lost.
module pixel_blend_unit #(
	parameter int FRAC_BITS = pbu_pkg::FRAC_BITS_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	pbu_pix_if.sink    sample,
	pbu_res_if.source  blended,
	pbu_cfg_if.sink    cfg
);

	localparam int QW = FRAC_BITS + 1;
	localparam int DW = FRAC_BITS + 2;
	localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

	logic [pbu_pkg::PIX_W-1:0]   draw_color_q;
	logic [pbu_pkg::MODE_W-1:0]  blend_mode_q;

	// Divider chain: index 0 is the front end output, index QW the output stage.
	logic           valid_c  [QW+1];
	logic           en_c     [QW+1];
	logic [DW-1:0]  rem_c    [QW+1];
	logic [QW-1:0]  nq_c     [QW+1];
	logic [DW-1:0]  den_c    [QW+1];
	logic [QW-1:0]  res_c    [QW+1];
	logic           is_div_c [QW+1];

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_color_q <= pbu_pkg::PIX_W'(ONE_Q);
			blend_mode_q <= pbu_pkg::MODE_LINEAR;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				pbu_pkg::CFG_DRAW_COLOR: begin
					draw_color_q <= cfg.data;
				end
				pbu_pkg::CFG_BLEND_MODE: begin
					blend_mode_q <= cfg.data[pbu_pkg::MODE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Front end: clamping, products, rounding and divider operands.
	pbu_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample.valid),
		.in_ready   (sample.ready),
		.pixel_in   (sample.pixel_in),
		.weight     (sample.weight),
		.draw_color (draw_color_q),
		.blend_mode (blend_mode_q),
		.en_next    (en_c[0]),
		.valid_s3   (valid_c[0]),
		.rem_s3     (rem_c[0]),
		.nq_s3      (nq_c[0]),
		.den_s3     (den_c[0]),
		.res_s3     (res_c[0]),
		.is_div_s3  (is_div_c[0])
	);

	// One divider stage per quotient bit.
	for (genvar k = 0; k < QW; k++) begin : g_div
		pbu_div_step #(
			.FRAC_BITS (FRAC_BITS)
		) u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (valid_c[k]),
			.ready_out (en_c[k]),
			.rem_in    (rem_c[k]),
			.nq_in     (nq_c[k]),
			.den_in    (den_c[k]),
			.res_in    (res_c[k]),
			.is_div_in (is_div_c[k]),
			.en_next   (en_c[k+1]),
			.valid_s1  (valid_c[k+1]),
			.rem_s1    (rem_c[k+1]),
			.nq_s1     (nq_c[k+1]),
			.den_s1    (den_c[k+1]),
			.res_s1    (res_c[k+1]),
			.is_div_s1 (is_div_c[k+1])
		);
	end

	// Output: the last divider stage is the output register.
	assign en_c[QW]          = blended.ready;
	assign blended.valid     = valid_c[QW];
	assign blended.pixel_out = pbu_pkg::PIX_W'(is_div_c[QW] ? nq_c[QW] : res_c[QW]);

endmodule

>>> src/pbu_front.sv
// Front end of the pixel blend unit: clamping, products, rounding and the
// per-mode results, in three register stages. Also forms the divider operands.
// Depends on pbu_pkg.
module pbu_front #(
	parameter int FRAC_BITS = pbu_pkg::FRAC_BITS_DEFAULT,
	localparam int QW = FRAC_BITS + 1,
	localparam int DW = FRAC_BITS + 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pbu_pkg::PIX_W-1:0]   pixel_in,
	input  logic [pbu_pkg::PIX_W-1:0]   weight,
	input  logic [pbu_pkg::PIX_W-1:0]   draw_color,
	input  logic [pbu_pkg::MODE_W-1:0]  blend_mode,
	input  logic                        en_next,
	output logic                        valid_s3,
	output logic [DW-1:0]               rem_s3,
	output logic [QW-1:0]               nq_s3,
	output logic [DW-1:0]               den_s3,
	output logic [QW-1:0]               res_s3,
	output logic                        is_div_s3
);

	// Clamped values never exceed ONE nor the 16-bit field.
	localparam int VW = (QW < pbu_pkg::PIX_W) ? QW : pbu_pkg::PIX_W;
	localparam int EW = (QW > pbu_pkg::PIX_W) ? QW : pbu_pkg::PIX_W;
	localparam int LW = QW + VW;
	localparam int SW = LW + 1;
	localparam int PW = ((2 * VW > FRAC_BITS) ? 2 * VW : FRAC_BITS) + 1;
	localparam int NW = 2 * FRAC_BITS + 3;

	localparam logic [QW-1:0] ONE_Q  = QW'(1) << FRAC_BITS;
	localparam logic [EW-1:0] ONE_E  = EW'(1) << FRAC_BITS;
	localparam logic [SW-1:0] HALF_L = SW'(1) << (FRAC_BITS - 1);
	localparam logic [PW-1:0] HALF_P = PW'(1) << (FRAC_BITS - 1);

	// Limit a field value to ONE.
	function automatic logic [VW-1:0] clamp_one(input logic [pbu_pkg::PIX_W-1:0] x);
		logic [EW-1:0] xe;
		xe = EW'(x);
		if (xe > ONE_E) begin
			xe = ONE_E;
		end
		return xe[VW-1:0];
	endfunction

	logic en_s1, en_s2, en_s3;
	logic valid_s1, valid_s2;

	logic [VW-1:0]               p_c, w_c, c_c;
	logic [QW-1:0]               one_minus_w;
	logic [LW-1:0]               lin_prod;
	logic [2*VW-1:0]             wc_prod;

	logic [LW-1:0]               lin_a_s1;
	logic [2*VW-1:0]             wc_s1;
	logic [VW-1:0]               p_s1;
	logic [pbu_pkg::MODE_W-1:0]  mode_s1;

	logic [SW-1:0]               lin_sum, lin_sh;
	logic [PW-1:0]               q_sum, q_sh;

	logic [QW-1:0]               lin_s2, q_s2;
	logic [VW-1:0]               p_s2;
	logic [pbu_pkg::MODE_W-1:0]  mode_s2;

	logic [DW-1:0]               pq, den;
	logic [QW-1:0]               clip;
	logic [NW-1:0]               num;
	logic [QW-1:0]               res_next;
	logic                        is_div_next;

	// A stage takes a new item when it is empty or its item moves on.
	assign en_s3    = !valid_s3 || en_next;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 1: clamp the operands and form both products.
	assign p_c         = clamp_one(pixel_in);
	assign w_c         = clamp_one(weight);
	assign c_c         = clamp_one(draw_color);
	assign one_minus_w = ONE_Q - QW'(w_c);
	assign lin_prod    = one_minus_w * p_c;
	assign wc_prod     = w_c * c_c;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			lin_a_s1 <= lin_prod;
			wc_s1    <= wc_prod;
			p_s1     <= p_c;
			mode_s1  <= blend_mode;
		end
	end

	// Stage 2: round the linear blend and the scaled color to nearest.
	assign lin_sum = SW'(lin_a_s1) + SW'(wc_s1) + HALF_L;
	assign lin_sh  = lin_sum >> FRAC_BITS;
	assign q_sum   = PW'(wc_s1) + HALF_P;
	assign q_sh    = q_sum >> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			lin_s2  <= lin_sh[QW-1:0];
			q_s2    <= q_sh[QW-1:0];
			p_s2    <= p_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: clipped sum, and dividend and divisor for the saturating mode.
	// The rounding offset of half the divisor is folded into the dividend.
	assign pq   = DW'(p_s2) + DW'(q_s2);
	assign clip = (pq > DW'(ONE_Q)) ? ONE_Q : pq[QW-1:0];
	assign den  = DW'(ONE_Q) + DW'(q_s2);
	assign num  = (NW'(pq) << FRAC_BITS) + NW'(den >> 1);

	always_comb begin
		case (mode_s2)
			pbu_pkg::MODE_ADD_CLIP: begin
				res_next    = clip;
				is_div_next = 1'b0;
			end
			pbu_pkg::MODE_ADD_SAT: begin
				res_next    = lin_s2;
				is_div_next = 1'b1;
			end
			default: begin
				res_next    = lin_s2;
				is_div_next = 1'b0;
			end
		endcase
	end

	// The quotient is at most ONE, so the dividend's top bits lie below the divisor.
	always_ff @(posedge clk) begin
		if (en_s3) begin
			rem_s3    <= num[NW-1:QW];
			nq_s3     <= num[QW-1:0];
			den_s3    <= den;
			res_s3    <= res_next;
			is_div_s3 <= is_div_next;
		end
	end

endmodule

>>> src/pbu_div_step.sv
// One register stage of the pipelined restoring divider: brings down one
// dividend bit, compares with the divisor and shifts in one quotient bit.
// Depends on pbu_pkg for the default fraction width.
module pbu_div_step #(
	parameter int FRAC_BITS = pbu_pkg::FRAC_BITS_DEFAULT,
	localparam int QW = FRAC_BITS + 1,
	localparam int DW = FRAC_BITS + 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_in,
	output logic           ready_out,
	input  logic [DW-1:0]  rem_in,
	input  logic [QW-1:0]  nq_in,
	input  logic [DW-1:0]  den_in,
	input  logic [QW-1:0]  res_in,
	input  logic           is_div_in,
	input  logic           en_next,
	output logic           valid_s1,
	output logic [DW-1:0]  rem_s1,
	output logic [QW-1:0]  nq_s1,
	output logic [DW-1:0]  den_s1,
	output logic [QW-1:0]  res_s1,
	output logic           is_div_s1
);

	logic            en_s1;
	logic [DW:0]     trial, diff;
	logic            ge;
	logic [DW-1:0]   rem_next;

	// This stage loads when empty or when its item moves on.
	assign en_s1     = !valid_s1 || en_next;
	assign ready_out = en_s1;

	// The next dividend bit enters at the bottom of the remainder; the free
	// low bit of the dividend word takes the new quotient bit.
	assign trial    = {rem_in, nq_in[QW-1]};
	assign diff     = trial - {1'b0, den_in};
	assign ge       = (trial >= {1'b0, den_in});
	assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			rem_s1    <= rem_next;
			nq_s1     <= {nq_in[QW-2:0], ge};
			den_s1    <= den_in;
			res_s1    <= res_in;
			is_div_s1 <= is_div_in;
		end
	end

endmodule
